/* hdl/srnt_pkg.sv */
// srnt_pkg: types and codes shared by the sorted ring neighbour table.
// Holds the item structs for both channels and the stored entry layout.
// No dependencies.
`timescale 1ns / 1ps

package srnt_pkg;

  localparam int KEY_W    = 25;
  localparam int HANDLE_W = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    longitude;
    logic [HANDLE_W-1:0] item_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] prec_id;
    logic [HANDLE_W-1:0] succ_id;
    logic                neighbors_valid;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hdl/sorted_ring_neighbor_table.sv */
// sorted_ring_neighbor_table: top level with the output item register.
// Depends on srnt_pkg and srnt_ctrl.
`timescale 1ns / 1ps

// Keeps up to CAPACITY handles sorted by longitude in one RAM and answers one
// item at a time. The sequencer reads one entry per cycle through the RAM's
// single read port. An insert walks down from the end of the table, shifting
// entries up as it goes until it reaches the insert place. A find walks up
// from the first entry; when the answer wraps at the first entry of a table of
// two or more it also reads the last entry for the predecessor, and a query
// beyond the last key is answered at the last entry. Clear, full, empty, unused
// codes and an insert into an empty table go straight to the response state.
// The result is then handed to the output register, which holds it while
// the next item is taken in.
module sorted_ring_neighbor_table #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  srnt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srnt_pkg::out_item_t out_data
);

  import srnt_pkg::*;

  logic      res_valid, res_take;
  out_item_t res;

  srnt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_data <= res;
    end
  end

endmodule

/* hdl/srnt_ram.sv */
// srnt_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module srnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/srnt_ctrl.sv */
// srnt_ctrl: sequencer that walks the entry RAM for insert and find.
// Depends on srnt_pkg and srnt_ram.
`timescale 1ns / 1ps

module srnt_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  srnt_pkg::in_item_t in_data,
  output logic               res_valid,
  output srnt_pkg::out_item_t res,
  input  logic               res_take
);

  import srnt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS       = 6'b000010,
    S_INS_PUT   = 6'b000100,
    S_FIND      = 6'b001000,
    S_FIND_LAST = 6'b010000,
    S_RESP      = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       idx, idx_next;
  logic [KEY_W-1:0]    key, key_next;
  logic [HANDLE_W-1:0] handle, handle_next;
  logic [HANDLE_W-1:0] first_handle, first_handle_next;
  logic [HANDLE_W-1:0] prev_handle, prev_handle_next;
  out_item_t           res_next;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  entry_t              wr_data, rd_data;
  logic [CW-1:0]       count_m1, idx_m1, idx_m2, idx_p1;

  srnt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_RESP);
  assign count_m1  = count - CW'(1);
  assign idx_m1    = idx - CW'(1);
  assign idx_m2    = idx_m1 - CW'(1);
  assign idx_p1    = idx + CW'(1);

  always_comb begin
    state_next        = state;
    count_next        = count;
    idx_next          = idx;
    key_next          = key;
    handle_next       = handle;
    first_handle_next = first_handle;
    prev_handle_next  = prev_handle;
    res_next          = res;
    wr_en             = 1'b0;
    wr_addr           = idx[AW-1:0];
    wr_data           = '{key: key, handle: handle};
    rd_en             = 1'b0;
    rd_addr           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_next    = '0;
          key_next    = in_data.longitude;
          handle_next = in_data.item_id;
          state_next  = S_RESP;
          case (in_data.op)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                res_next.status = ST_FULL;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{key: in_data.longitude, handle: in_data.item_id};
                count_next = CW'(1);
              end else begin
                rd_en      = 1'b1;
                rd_addr    = count_m1[AW-1:0];
                idx_next   = count;
                state_next = S_INS;
              end
            end
            OP_FIND: begin
              if (count == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_FIND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        // rd_data holds entry idx-1; either place the new item or shift up
        wr_en = 1'b1;
        if (key > rd_data.key) begin
          count_next = count + CW'(1);
          state_next = S_RESP;
        end else begin
          wr_data  = rd_data;
          idx_next = idx_m1;
          if (idx == CW'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_m2[AW-1:0];
          end
        end
      end
      S_INS_PUT: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
        state_next = S_RESP;
      end
      S_FIND: begin
        if (idx == '0) begin
          first_handle_next = rd_data.handle;
        end
        if (rd_data.key >= key) begin
          res_next.status          = ST_OK;
          res_next.neighbors_valid = 1'b1;
          if (idx == '0) begin
            if (count == CW'(1)) begin
              res_next.prec_id = rd_data.handle;
              res_next.succ_id = rd_data.handle;
              state_next       = S_RESP;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = count_m1[AW-1:0];
              state_next = S_FIND_LAST;
            end
          end else begin
            res_next.prec_id = prev_handle;
            res_next.succ_id = rd_data.handle;
            state_next       = S_RESP;
          end
        end else if (idx == count_m1) begin
          // query beyond the last key: wrap round
          res_next.status          = ST_OK;
          res_next.neighbors_valid = 1'b1;
          res_next.prec_id         = rd_data.handle;
          res_next.succ_id         = (idx == '0) ? rd_data.handle : first_handle;
          state_next               = S_RESP;
        end else begin
          prev_handle_next = rd_data.handle;
          idx_next         = idx_p1;
          rd_en            = 1'b1;
          rd_addr          = idx_p1[AW-1:0];
        end
      end
      S_FIND_LAST: begin
        res_next.prec_id = rd_data.handle;
        res_next.succ_id = first_handle;
        state_next       = S_RESP;
      end
      S_RESP: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx          <= idx_next;
    key          <= key_next;
    handle       <= handle_next;
    first_handle <= first_handle_next;
    prev_handle  <= prev_handle_next;
    res          <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> count == $past(count) + CW'(1) || count == '0)
    else $error("entry count moved by other than one or clear");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == OP_CLEAR |=> count == '0 && state == S_RESP)
    else $error("clear did not empty the table");

  a_nv_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.neighbors_valid |-> res.status == ST_OK)
    else $error("neighbours flagged with non-ok status");

endmodule
